// ----- rtl/core/json_byte_tokenizer_defines.svh -----
// Assertion macros used by the checker file of the tokenizer.
`ifndef JSON_BYTE_TOKENIZER_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JBT_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define JBT_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// ----- rtl/core/jbt_pkg.sv -----
package jbt_pkg;

	// Lexer modes.
	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_NUM     = 3'd1;
	localparam logic [2:0] MODE_NUM_DOT = 3'd2;
	localparam logic [2:0] MODE_STR     = 3'd3;
	localparam logic [2:0] MODE_STR_ESC = 3'd4;
	localparam logic [2:0] MODE_WORD    = 3'd5;

	// Token kinds.
	localparam logic [3:0] TK_LBRACE    = 4'd0;
	localparam logic [3:0] TK_RBRACE    = 4'd1;
	localparam logic [3:0] TK_LBRACKET  = 4'd2;
	localparam logic [3:0] TK_RBRACKET  = 4'd3;
	localparam logic [3:0] TK_MINUS     = 4'd4;
	localparam logic [3:0] TK_COLON     = 4'd5;
	localparam logic [3:0] TK_COMMA     = 4'd6;
	localparam logic [3:0] TK_UNKNOWN   = 4'd7;
	localparam logic [3:0] TK_NUMBER    = 4'd8;
	localparam logic [3:0] TK_STRING    = 4'd9;
	localparam logic [3:0] TK_TRUE      = 4'd10;
	localparam logic [3:0] TK_FALSE     = 4'd11;
	localparam logic [3:0] TK_NULL      = 4'd12;
	localparam logic [3:0] TK_UNDEFINED = 4'd13;
	localparam logic [3:0] TK_END       = 4'd14;
	localparam logic [3:0] TK_ERROR     = 4'd15;

	// Result events.
	localparam logic [1:0] EV_WHOLE = 2'd0;
	localparam logic [1:0] EV_BODY  = 2'd1;
	localparam logic [1:0] EV_END   = 2'd2;

	// Configuration register indexes.
	localparam logic CFG_START_LINE   = 1'b0;
	localparam logic CFG_START_COLUMN = 1'b1;

	localparam logic [15:0] RESET_LINE   = 16'd1;
	localparam logic [15:0] RESET_COLUMN = 16'd0;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} jbt_in_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [1:0]  event_res;
		logic [7:0]  body_byte;
		logic [15:0] token_line;
		logic [15:0] token_column;
		logic        last_result;
	} jbt_out_t;

	// Lexer state; kw_match holds the still-possible keywords (high three bits,
	// true/false/null) over the word length saturating at seven (low three bits).
	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] line_count;
		logic [15:0] column_count;
		logic [15:0] start_line_held;
		logic [15:0] start_column_held;
		logic        decimal_seen;
		logic [5:0]  kw_match;
	} jbt_state_t;

	localparam jbt_state_t STATE_RESET = {MODE_IDLE, RESET_LINE, RESET_COLUMN,
		16'd0, 16'd0, 1'b0, 6'd0};

	// All results that one input transaction causes.
	typedef struct packed {
		logic [1:0]           cnt;
		jbt_out_t [2:0]       res;
	} jbt_group_t;

endpackage

// ----- rtl/core/jbt_step.sv -----
module jbt_step (
	input  jbt_pkg::jbt_state_t st,
	input  jbt_pkg::jbt_in_t    item,
	output jbt_pkg::jbt_state_t nxt,
	output jbt_pkg::jbt_group_t grp
);

	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;

	localparam logic [1:0] KW_TRUE  = 2'd0;
	localparam logic [1:0] KW_FALSE = 2'd1;
	localparam logic [1:0] KW_NULL  = 2'd2;

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic is_digit(input logic [7:0] ch);
		return (ch >= "0") && (ch <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] ch);
		return ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
	endfunction

	function automatic logic is_space(input logic [7:0] ch);
		return (ch == CH_SPACE) || ((ch >= 8'd9) && (ch <= 8'd13));
	endfunction

	function automatic logic [2:0] kw_len(input logic [1:0] k);
		return (k == KW_FALSE) ? 3'd5 : 3'd4;
	endfunction

	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [7:0] ch;
		ch = 8'h00;
		unique case (k)
			KW_TRUE: begin
				unique case (pos)
					3'd0: ch = "t";
					3'd1: ch = "r";
					3'd2: ch = "u";
					3'd3: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			KW_FALSE: begin
				unique case (pos)
					3'd0: ch = "f";
					3'd1: ch = "a";
					3'd2: ch = "l";
					3'd3: ch = "s";
					3'd4: ch = "e";
					default: ch = 8'h00;
				endcase
			end
			KW_NULL: begin
				unique case (pos)
					3'd0: ch = "n";
					3'd1: ch = "u";
					3'd2: ch = "l";
					3'd3: ch = "l";
					default: ch = 8'h00;
				endcase
			end
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic [5:0] word_add(input logic [5:0] km, input logic [7:0] ch);
		logic [2:0] len;
		logic [2:0] mask;
		len  = km[2:0];
		mask = km[5:3];
		for (int k = 0; k < 3; k++) begin
			if ((len >= kw_len(k[1:0])) || (kw_char(k[1:0], len) != ch))
				mask[k] = 1'b0;
		end
		if (len != 3'd7)
			len = len + 3'd1;
		return {mask, len};
	endfunction

	function automatic logic [3:0] word_kind(input logic [5:0] km);
		logic [3:0] kind;
		kind = jbt_pkg::TK_UNDEFINED;
		if (km[3 + KW_TRUE] && (km[2:0] == kw_len(KW_TRUE)))
			kind = jbt_pkg::TK_TRUE;
		if (km[3 + KW_FALSE] && (km[2:0] == kw_len(KW_FALSE)))
			kind = jbt_pkg::TK_FALSE;
		if (km[3 + KW_NULL] && (km[2:0] == kw_len(KW_NULL)))
			kind = jbt_pkg::TK_NULL;
		return kind;
	endfunction

	function automatic jbt_pkg::jbt_out_t mk(input logic [3:0] kind, input logic [1:0] ev,
			input logic [7:0] b, input logic [15:0] ln, input logic [15:0] col);
		jbt_pkg::jbt_out_t r;
		r.token_kind   = kind;
		r.event_res    = ev;
		r.body_byte    = b;
		r.token_line   = ln;
		r.token_column = col;
		r.last_result  = 1'b0;
		return r;
	endfunction

	function automatic logic [3:0] punct_kind(input logic [7:0] ch);
		logic [3:0] kind;
		unique case (ch)
			"{":     kind = jbt_pkg::TK_LBRACE;
			"}":     kind = jbt_pkg::TK_RBRACE;
			"[":     kind = jbt_pkg::TK_LBRACKET;
			"]":     kind = jbt_pkg::TK_RBRACKET;
			"-":     kind = jbt_pkg::TK_MINUS;
			":":     kind = jbt_pkg::TK_COLON;
			",":     kind = jbt_pkg::TK_COMMA;
			default: kind = jbt_pkg::TK_UNKNOWN;
		endcase
		return kind;
	endfunction

	jbt_pkg::jbt_out_t [2:0] res;
	logic [1:0]  n;
	logic        do_idle;
	logic        err;
	logic [7:0]  c;
	logic [15:0] hl;
	logic [15:0] hc;

	always_comb begin
		nxt     = st;
		res     = '0;
		n       = 2'd0;
		do_idle = 1'b0;
		err     = 1'b0;
		c       = item.char_byte;
		hl      = st.start_line_held;
		hc      = st.start_column_held;
		if (item.end_of_input) begin
			unique case (st.mode)
				jbt_pkg::MODE_NUM, jbt_pkg::MODE_NUM_DOT: begin
					res[n] = mk(jbt_pkg::TK_NUMBER, jbt_pkg::EV_END, 8'h00, hl, hc);
					n = n + 2'd1;
				end
				jbt_pkg::MODE_WORD: begin
					res[n] = mk(word_kind(st.kw_match), jbt_pkg::EV_WHOLE, 8'h00, hl, hc);
					n = n + 2'd1;
				end
				jbt_pkg::MODE_STR, jbt_pkg::MODE_STR_ESC: begin
					res[n] = mk(jbt_pkg::TK_ERROR, jbt_pkg::EV_WHOLE, 8'h00, hl, hc);
					n = n + 2'd1;
					err = 1'b1;
				end
				default: begin
				end
			endcase
			if (!err) begin
				res[n] = mk(jbt_pkg::TK_END, jbt_pkg::EV_WHOLE, 8'h00, st.line_count,
					sat_inc(st.column_count));
				n = n + 2'd1;
			end
			nxt.mode         = jbt_pkg::MODE_IDLE;
			nxt.decimal_seen = 1'b0;
		end else begin
			nxt.column_count = sat_inc(st.column_count);
			if (c == CH_NEWLINE) begin
				nxt.line_count   = sat_inc(st.line_count);
				nxt.column_count = 16'd0;
			end
			unique case (st.mode)
				jbt_pkg::MODE_NUM: begin
					if (is_digit(c)) begin
						res[n] = mk(jbt_pkg::TK_NUMBER, jbt_pkg::EV_BODY, c, hl, hc);
						n = n + 2'd1;
					end else if ((c == CH_DOT) && !st.decimal_seen) begin
						nxt.mode = jbt_pkg::MODE_NUM_DOT;
					end else begin
						res[n] = mk(jbt_pkg::TK_NUMBER, jbt_pkg::EV_END, 8'h00, hl, hc);
						n = n + 2'd1;
						nxt.decimal_seen = 1'b0;
						do_idle = 1'b1;
					end
				end
				jbt_pkg::MODE_NUM_DOT: begin
					if (c == CH_DOT) begin
						// Double dot: the held dot is dropped.
						res[n] = mk(jbt_pkg::TK_NUMBER, jbt_pkg::EV_END, 8'h00, hl, hc);
						n = n + 2'd1;
						nxt.decimal_seen = 1'b0;
						do_idle = 1'b1;
					end else begin
						res[n] = mk(jbt_pkg::TK_NUMBER, jbt_pkg::EV_BODY, CH_DOT, hl, hc);
						n = n + 2'd1;
						nxt.decimal_seen = 1'b1;
						nxt.mode = jbt_pkg::MODE_NUM;
						if (is_digit(c)) begin
							res[n] = mk(jbt_pkg::TK_NUMBER, jbt_pkg::EV_BODY, c, hl, hc);
							n = n + 2'd1;
						end else begin
							res[n] = mk(jbt_pkg::TK_NUMBER, jbt_pkg::EV_END, 8'h00, hl, hc);
							n = n + 2'd1;
							nxt.decimal_seen = 1'b0;
							do_idle = 1'b1;
						end
					end
				end
				jbt_pkg::MODE_STR: begin
					if (c == CH_QUOTE) begin
						res[n] = mk(jbt_pkg::TK_STRING, jbt_pkg::EV_END, 8'h00, hl, hc);
						n = n + 2'd1;
						nxt.mode = jbt_pkg::MODE_IDLE;
					end else begin
						res[n] = mk(jbt_pkg::TK_STRING, jbt_pkg::EV_BODY, c, hl, hc);
						n = n + 2'd1;
						if (c == CH_BACKSLASH)
							nxt.mode = jbt_pkg::MODE_STR_ESC;
					end
				end
				jbt_pkg::MODE_STR_ESC: begin
					res[n] = mk(jbt_pkg::TK_STRING, jbt_pkg::EV_BODY, c, hl, hc);
					n = n + 2'd1;
					nxt.mode = jbt_pkg::MODE_STR;
				end
				jbt_pkg::MODE_WORD: begin
					if (is_alpha(c) || (c == CH_UNDERSCORE)) begin
						nxt.kw_match = word_add(st.kw_match, c);
					end else begin
						res[n] = mk(word_kind(st.kw_match), jbt_pkg::EV_WHOLE, 8'h00, hl, hc);
						n = n + 2'd1;
						do_idle = 1'b1;
					end
				end
				default: do_idle = 1'b1;
			endcase
			// The byte that ends a number or word, or any byte in idle mode, starts the next token here.
			if (do_idle) begin
				nxt.mode = jbt_pkg::MODE_IDLE;
				if (is_space(c)) begin
				end else if (is_digit(c)) begin
					nxt.start_line_held   = nxt.line_count;
					nxt.start_column_held = nxt.column_count;
					nxt.decimal_seen      = 1'b0;
					nxt.mode              = jbt_pkg::MODE_NUM;
					res[n] = mk(jbt_pkg::TK_NUMBER, jbt_pkg::EV_BODY, c, nxt.line_count,
						nxt.column_count);
					n = n + 2'd1;
				end else if (is_alpha(c)) begin
					nxt.start_line_held   = nxt.line_count;
					nxt.start_column_held = nxt.column_count;
					nxt.kw_match          = word_add(6'b111_000, c);
					nxt.mode              = jbt_pkg::MODE_WORD;
				end else if (c == CH_QUOTE) begin
					nxt.start_line_held   = nxt.line_count;
					nxt.start_column_held = nxt.column_count;
					nxt.mode              = jbt_pkg::MODE_STR;
				end else begin
					res[n] = mk(punct_kind(c), jbt_pkg::EV_WHOLE, 8'h00, nxt.line_count,
						nxt.column_count);
					n = n + 2'd1;
				end
			end
		end
		if (n != 2'd0)
			res[n - 2'd1].last_result = 1'b1;
		grp.cnt = n;
		grp.res = res;
	end

endmodule

// ----- rtl/core/jbt_outq.sv -----
module jbt_outq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  jbt_pkg::jbt_group_t grp_in,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output jbt_pkg::jbt_out_t   out_data
);

	jbt_pkg::jbt_group_t grp_q;
	logic [1:0]          idx_q;
	logic                valid_q;
	logic                at_last;

	assign at_last   = (idx_q == (grp_q.cnt - 2'd1));
	assign can_load  = !valid_q || (out_ready && at_last);
	assign out_valid = valid_q;
	assign out_data  = grp_q.res[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 2'd0;
		end else if (valid_q && out_ready) begin
			if (at_last)
				valid_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			grp_q <= grp_in;
	end

endmodule

// ----- rtl/core/json_byte_tokenizer.sv -----
// An accepted transaction is captured in the input register; its results are formed
// combinationally and loaded into the output register once that can load.
// Throughput: one transaction per cycle while the output queue can take its results;
// the output drains one result of a group per cycle while out_ready is high.
// Reset clears all control state and loads line 1, column 0; no clearing pass.
module json_byte_tokenizer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  jbt_pkg::jbt_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output jbt_pkg::jbt_out_t out_data,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_wdata
);

	logic                valid_s1;
	jbt_pkg::jbt_in_t    item_s1;
	jbt_pkg::jbt_state_t st_q;
	jbt_pkg::jbt_state_t st_nxt;
	jbt_pkg::jbt_state_t st_d;
	jbt_pkg::jbt_group_t grp;
	logic                can_load;
	logic                advance;
	logic                load;

	// An item that causes no result moves on without touching the output side.
	assign advance  = valid_s1 && ((grp.cnt == 2'd0) || can_load);
	assign load     = advance && (grp.cnt != 2'd0);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			item_s1 <= in_data;
	end

	always_comb begin
		st_d = advance ? st_nxt : st_q;
		if (cfg_we) begin
			unique case (cfg_index)
				jbt_pkg::CFG_START_LINE:   st_d.line_count   = cfg_wdata;
				jbt_pkg::CFG_START_COLUMN: st_d.column_count = cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= jbt_pkg::STATE_RESET;
		end else begin
			st_q <= st_d;
		end
	end

	jbt_step u_step (
		.st   (st_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.grp  (grp)
	);

	jbt_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.grp_in    (grp),
		.can_load  (can_load),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- rtl/core/jbt_checker.sv -----
`include "json_byte_tokenizer_defines.svh"

module jbt_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_ready,
	input jbt_pkg::jbt_out_t out_data
);

	logic body_ev;
	logic known_ev;
	logic final_kind;
	logic final_ok;

	assign body_ev    = (out_data.event_res == jbt_pkg::EV_BODY);
	assign known_ev   = (out_data.event_res == jbt_pkg::EV_WHOLE) || body_ev ||
		(out_data.event_res == jbt_pkg::EV_END);
	assign final_kind = (out_data.token_kind == jbt_pkg::TK_END) ||
		(out_data.token_kind == jbt_pkg::TK_ERROR);
	assign final_ok   = out_data.last_result && (out_data.event_res == jbt_pkg::EV_WHOLE);

	`JBT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`JBT_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_data))
	`JBT_ASSERT_SAME(a_body_zero, clk, arst_n, out_valid && !body_ev, out_data.body_byte == 8'h00)
	`JBT_ASSERT_SAME(a_event_code, clk, arst_n, out_valid, known_ev)
	`JBT_ASSERT_SAME(a_final_token, clk, arst_n, out_valid && final_kind, final_ok)

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
